@@ src/jtt_pkg.sv @@
// ----------------------------------------------------------------------------
// jtt_pkg: shared types and constants for the tap tms path tracker
// tap state codes, command codes and the step unit request/response structs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jtt_pkg;

  localparam int STATE_W       = 4;
  localparam int TMS_BITS_W    = 8;
  localparam int TMS_COUNT_W   = 4;
  localparam int PATH_BITS_DEF = 8;

  localparam logic [STATE_W-1:0] ST_RESET      = 4'd0;
  localparam logic [STATE_W-1:0] ST_IDLE       = 4'd1;
  localparam logic [STATE_W-1:0] ST_SELECT_DR  = 4'd2;
  localparam logic [STATE_W-1:0] ST_CAPTURE_DR = 4'd3;
  localparam logic [STATE_W-1:0] ST_SHIFT_DR   = 4'd4;
  localparam logic [STATE_W-1:0] ST_EXIT1_DR   = 4'd5;
  localparam logic [STATE_W-1:0] ST_PAUSE_DR   = 4'd6;
  localparam logic [STATE_W-1:0] ST_EXIT2_DR   = 4'd7;
  localparam logic [STATE_W-1:0] ST_UPDATE_DR  = 4'd8;
  localparam logic [STATE_W-1:0] ST_SELECT_IR  = 4'd9;
  localparam logic [STATE_W-1:0] ST_CAPTURE_IR = 4'd10;
  localparam logic [STATE_W-1:0] ST_SHIFT_IR   = 4'd11;
  localparam logic [STATE_W-1:0] ST_EXIT1_IR   = 4'd12;
  localparam logic [STATE_W-1:0] ST_PAUSE_IR   = 4'd13;
  localparam logic [STATE_W-1:0] ST_EXIT2_IR   = 4'd14;
  localparam logic [STATE_W-1:0] ST_UPDATE_IR  = 4'd15;

  localparam logic CMD_GOTO = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic [STATE_W-1:0] target;
    logic               raw_tms;
    logic               use_raw;
  } step_req_t;

  typedef struct packed {
    logic               tms;
    logic [STATE_W-1:0] next;
  } step_rsp_t;

endpackage

`default_nettype wire

@@ src/jtt_step_unit.sv @@
// ----------------------------------------------------------------------------
// jtt_step_unit: one tap step
// picks the tms bit toward the target (or takes the raw bit) and gives the
// next tap state from the standard next-state table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jtt_step_unit (
  input  var jtt_pkg::step_req_t req,
  output var jtt_pkg::step_rsp_t rsp
);

  logic                        choice;
  logic                        tms;
  logic [jtt_pkg::STATE_W-1:0] t;

  assign t = req.target;

  always_comb begin
    case (req.state)
      jtt_pkg::ST_RESET:      choice = 1'b0;
      jtt_pkg::ST_IDLE:       choice = 1'b1;
      jtt_pkg::ST_SELECT_DR:  choice = !(t >= jtt_pkg::ST_SELECT_DR && t <= jtt_pkg::ST_UPDATE_DR);
      jtt_pkg::ST_CAPTURE_DR: choice = (t != jtt_pkg::ST_SHIFT_DR);
      jtt_pkg::ST_SHIFT_DR:   choice = 1'b1;
      jtt_pkg::ST_EXIT1_DR:   choice = !(t == jtt_pkg::ST_PAUSE_DR || t == jtt_pkg::ST_EXIT2_DR);
      jtt_pkg::ST_PAUSE_DR:   choice = 1'b1;
      jtt_pkg::ST_EXIT2_DR:   choice = (t != jtt_pkg::ST_SHIFT_DR);
      jtt_pkg::ST_UPDATE_DR:  choice = (t != jtt_pkg::ST_IDLE);
      jtt_pkg::ST_SELECT_IR:  choice = !(t >= jtt_pkg::ST_SELECT_IR);
      jtt_pkg::ST_CAPTURE_IR: choice = (t != jtt_pkg::ST_SHIFT_IR);
      jtt_pkg::ST_SHIFT_IR:   choice = 1'b1;
      jtt_pkg::ST_EXIT1_IR:   choice = !(t == jtt_pkg::ST_PAUSE_IR || t == jtt_pkg::ST_EXIT2_IR);
      jtt_pkg::ST_PAUSE_IR:   choice = 1'b1;
      jtt_pkg::ST_EXIT2_IR:   choice = (t != jtt_pkg::ST_SHIFT_IR);
      default:                choice = (t != jtt_pkg::ST_IDLE);
    endcase
  end

  assign tms = req.use_raw ? req.raw_tms : choice;

  always_comb begin
    case (req.state)
      jtt_pkg::ST_RESET:      rsp.next = tms ? jtt_pkg::ST_RESET      : jtt_pkg::ST_IDLE;
      jtt_pkg::ST_IDLE:       rsp.next = tms ? jtt_pkg::ST_SELECT_DR  : jtt_pkg::ST_IDLE;
      jtt_pkg::ST_SELECT_DR:  rsp.next = tms ? jtt_pkg::ST_SELECT_IR  : jtt_pkg::ST_CAPTURE_DR;
      jtt_pkg::ST_CAPTURE_DR: rsp.next = tms ? jtt_pkg::ST_EXIT1_DR   : jtt_pkg::ST_SHIFT_DR;
      jtt_pkg::ST_SHIFT_DR:   rsp.next = tms ? jtt_pkg::ST_EXIT1_DR   : jtt_pkg::ST_SHIFT_DR;
      jtt_pkg::ST_EXIT1_DR:   rsp.next = tms ? jtt_pkg::ST_UPDATE_DR  : jtt_pkg::ST_PAUSE_DR;
      jtt_pkg::ST_PAUSE_DR:   rsp.next = tms ? jtt_pkg::ST_EXIT2_DR   : jtt_pkg::ST_PAUSE_DR;
      jtt_pkg::ST_EXIT2_DR:   rsp.next = tms ? jtt_pkg::ST_UPDATE_DR  : jtt_pkg::ST_SHIFT_DR;
      jtt_pkg::ST_UPDATE_DR:  rsp.next = tms ? jtt_pkg::ST_SELECT_DR  : jtt_pkg::ST_IDLE;
      jtt_pkg::ST_SELECT_IR:  rsp.next = tms ? jtt_pkg::ST_RESET      : jtt_pkg::ST_CAPTURE_IR;
      jtt_pkg::ST_CAPTURE_IR: rsp.next = tms ? jtt_pkg::ST_EXIT1_IR   : jtt_pkg::ST_SHIFT_IR;
      jtt_pkg::ST_SHIFT_IR:   rsp.next = tms ? jtt_pkg::ST_EXIT1_IR   : jtt_pkg::ST_SHIFT_IR;
      jtt_pkg::ST_EXIT1_IR:   rsp.next = tms ? jtt_pkg::ST_UPDATE_IR  : jtt_pkg::ST_PAUSE_IR;
      jtt_pkg::ST_PAUSE_IR:   rsp.next = tms ? jtt_pkg::ST_EXIT2_IR   : jtt_pkg::ST_PAUSE_IR;
      jtt_pkg::ST_EXIT2_IR:   rsp.next = tms ? jtt_pkg::ST_UPDATE_IR  : jtt_pkg::ST_SHIFT_IR;
      default:                rsp.next = tms ? jtt_pkg::ST_SELECT_DR  : jtt_pkg::ST_IDLE;
    endcase
  end

  assign rsp.tms = tms;

endmodule

`default_nettype wire

@@ src/jtag_tap_tms_path_tracker.sv @@
// sequencing: a transfer starts a walk; a step or a goto to the current state
// finishes without walking, a goto with an n-bit path (n at most PATH_BITS) after
// n tap steps, one per cycle through the shared step unit; finish waits while the
// result is stalled, and no new command is taken until the sequencer is idle
// reset: rst clears the sequencer and the result valid, tracked state goes to
// test logic reset
// ----------------------------------------------------------------------------
// jtag_tap_tms_path_tracker: jtag tap state tracker with tms path generation
// sequencer that walks the tap state one step per cycle toward a target
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jtag_tap_tms_path_tracker #(
  parameter int PATH_BITS = jtt_pkg::PATH_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cmd_valid,
  output logic                              cmd_stall,
  input  wire                               command,
  input  wire  [jtt_pkg::STATE_W-1:0]       target_state,
  input  wire                               tms_bit,
  output logic                              rsp_valid,
  input  wire                               rsp_stall,
  output logic [jtt_pkg::TMS_BITS_W-1:0]    tms_bits,
  output logic [jtt_pkg::TMS_COUNT_W-1:0]   tms_count,
  output logic [jtt_pkg::STATE_W-1:0]       new_state
);

  localparam int CNT_W = $clog2(PATH_BITS + 1);
  localparam logic SEQ_IDLE = 1'b0;
  localparam logic SEQ_WALK = 1'b1;

  logic                            seq;
  logic                            seq_next;
  logic [jtt_pkg::STATE_W-1:0]     tracked;
  logic [jtt_pkg::STATE_W-1:0]     walk_state;
  logic [jtt_pkg::STATE_W-1:0]     target;
  logic                            cmd;
  logic                            raw_tms;
  logic [CNT_W-1:0]                cnt;
  logic [jtt_pkg::TMS_BITS_W-1:0]  bits;
  logic                            take;
  logic                            slot_free;
  logic                            at_end;
  logic                            finish;
  jtt_pkg::step_req_t              req;
  jtt_pkg::step_rsp_t              rsp;

  assign cmd_stall = (seq != SEQ_IDLE);
  assign take      = cmd_valid && !cmd_stall;
  assign slot_free = !rsp_valid || !rsp_stall;
  assign at_end    = (walk_state == target) || (cnt == CNT_W'(PATH_BITS));
  assign finish    = (seq == SEQ_WALK) && slot_free && ((cmd == jtt_pkg::CMD_STEP) || at_end);

  assign req.state   = walk_state;
  assign req.target  = target;
  assign req.raw_tms = raw_tms;
  assign req.use_raw = (cmd == jtt_pkg::CMD_STEP);

  jtt_step_unit u_step (
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    seq_next = seq;
    case (seq)
      SEQ_IDLE: begin
        if (take) begin
          seq_next = SEQ_WALK;
        end
      end
      SEQ_WALK: begin
        if (finish) begin
          seq_next = SEQ_IDLE;
        end
      end
      default: seq_next = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= SEQ_IDLE;
      tracked   <= jtt_pkg::ST_RESET;
      rsp_valid <= 1'b0;
    end else begin
      seq <= seq_next;
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (finish) begin
        rsp_valid <= 1'b1;
        if (cmd == jtt_pkg::CMD_STEP) begin
          tracked <= rsp.next;
        end else begin
          tracked <= target;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd        <= command;
      target     <= target_state;
      raw_tms    <= tms_bit;
      walk_state <= tracked;
      cnt        <= '0;
      bits       <= '0;
    end else if (seq == SEQ_WALK && cmd == jtt_pkg::CMD_GOTO && !at_end) begin
      bits       <= bits | (jtt_pkg::TMS_BITS_W'(rsp.tms) << cnt);
      cnt        <= cnt + CNT_W'(1);
      walk_state <= rsp.next;
    end
    if (finish) begin
      if (cmd == jtt_pkg::CMD_STEP) begin
        tms_bits  <= jtt_pkg::TMS_BITS_W'(raw_tms);
        tms_count <= jtt_pkg::TMS_COUNT_W'(1);
        new_state <= rsp.next;
      end else begin
        tms_bits  <= bits;
        tms_count <= jtt_pkg::TMS_COUNT_W'(cnt);
        new_state <= target;
      end
    end
  end

`ifndef SYNTH
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    take |=> cmd_stall)
    else $error("sequencer not busy after transfer");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> tms_count <= jtt_pkg::TMS_COUNT_W'(PATH_BITS))
    else $error("tms count beyond path bound");

  a_empty_path: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && tms_count == '0 |-> tms_bits == '0)
    else $error("bits set on empty path");

  a_state_match: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> new_state == tracked)
    else $error("result state differs from tracked state");

  a_bits_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (tms_bits >> tms_count) == '0)
    else $error("bits above count not zero");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_jtag_tap_tms_path_tracker.sv @@
// ----------------------------------------------------------------------------
// tb_jtag_tap_tms_path_tracker: self-checking bench for the tap path tracker
// drives goto and raw step commands from a queue, predicts the tms path, count
// and tracked state of every transfer, and compares each result in order
// under several sender idle and receiver stall patterns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_jtag_tap_tms_path_tracker;

  localparam int PATH_STEPS  = 8;
  localparam int ITEMS_PHASE = 240;
  localparam int DRAIN_WAIT  = 20;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} idle_mode_t;

  typedef struct {
    logic                        command;
    logic [jtt_pkg::STATE_W-1:0] target;
    logic                        tms;
  } tap_cmd_t;

  typedef struct {
    logic [jtt_pkg::TMS_BITS_W-1:0]  bits;
    logic [jtt_pkg::TMS_COUNT_W-1:0] count;
    logic [jtt_pkg::STATE_W-1:0]     state;
  } tms_path_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  logic command = jtt_pkg::CMD_GOTO;
  logic [jtt_pkg::STATE_W-1:0] target_state = jtt_pkg::ST_RESET;
  logic tms_bit = 1'b0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [jtt_pkg::TMS_BITS_W-1:0] tms_bits;
  logic [jtt_pkg::TMS_COUNT_W-1:0] tms_count;
  logic [jtt_pkg::STATE_W-1:0] new_state;

  tap_cmd_t   cmd_queue[$];
  tms_path_t  path_queue[$];
  idle_mode_t idle_mode = PH_FREE;
  logic [jtt_pkg::STATE_W-1:0] model_state = jtt_pkg::ST_RESET;
  int errors = 0;
  int cycles = 0;
  int gotos_sent = 0;
  int steps_sent = 0;
  int results_seen = 0;

  jtag_tap_tms_path_tracker dut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .command      (command),
    .target_state (target_state),
    .tms_bit      (tms_bit),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .tms_bits     (tms_bits),
    .tms_count    (tms_count),
    .new_state    (new_state)
  );

  always #5 clk = ~clk;

  function automatic logic [jtt_pkg::STATE_W-1:0] tap_next(logic [jtt_pkg::STATE_W-1:0] s,
                                                            logic tms);
    case (s)
      jtt_pkg::ST_RESET:      return tms ? jtt_pkg::ST_RESET     : jtt_pkg::ST_IDLE;
      jtt_pkg::ST_IDLE:       return tms ? jtt_pkg::ST_SELECT_DR : jtt_pkg::ST_IDLE;
      jtt_pkg::ST_SELECT_DR:  return tms ? jtt_pkg::ST_SELECT_IR : jtt_pkg::ST_CAPTURE_DR;
      jtt_pkg::ST_CAPTURE_DR: return tms ? jtt_pkg::ST_EXIT1_DR  : jtt_pkg::ST_SHIFT_DR;
      jtt_pkg::ST_SHIFT_DR:   return tms ? jtt_pkg::ST_EXIT1_DR  : jtt_pkg::ST_SHIFT_DR;
      jtt_pkg::ST_EXIT1_DR:   return tms ? jtt_pkg::ST_UPDATE_DR : jtt_pkg::ST_PAUSE_DR;
      jtt_pkg::ST_PAUSE_DR:   return tms ? jtt_pkg::ST_EXIT2_DR  : jtt_pkg::ST_PAUSE_DR;
      jtt_pkg::ST_EXIT2_DR:   return tms ? jtt_pkg::ST_UPDATE_DR : jtt_pkg::ST_SHIFT_DR;
      jtt_pkg::ST_UPDATE_DR:  return tms ? jtt_pkg::ST_SELECT_DR : jtt_pkg::ST_IDLE;
      jtt_pkg::ST_SELECT_IR:  return tms ? jtt_pkg::ST_RESET     : jtt_pkg::ST_CAPTURE_IR;
      jtt_pkg::ST_CAPTURE_IR: return tms ? jtt_pkg::ST_EXIT1_IR  : jtt_pkg::ST_SHIFT_IR;
      jtt_pkg::ST_SHIFT_IR:   return tms ? jtt_pkg::ST_EXIT1_IR  : jtt_pkg::ST_SHIFT_IR;
      jtt_pkg::ST_EXIT1_IR:   return tms ? jtt_pkg::ST_UPDATE_IR : jtt_pkg::ST_PAUSE_IR;
      jtt_pkg::ST_PAUSE_IR:   return tms ? jtt_pkg::ST_EXIT2_IR  : jtt_pkg::ST_PAUSE_IR;
      jtt_pkg::ST_EXIT2_IR:   return tms ? jtt_pkg::ST_UPDATE_IR : jtt_pkg::ST_SHIFT_IR;
      default:                return tms ? jtt_pkg::ST_SELECT_DR : jtt_pkg::ST_IDLE;
    endcase
  endfunction

  function automatic logic walk_choice(logic [jtt_pkg::STATE_W-1:0] s,
                                       logic [jtt_pkg::STATE_W-1:0] t);
    case (s)
      jtt_pkg::ST_RESET:      return 1'b0;
      jtt_pkg::ST_IDLE:       return 1'b1;
      jtt_pkg::ST_SELECT_DR:  return !(t >= jtt_pkg::ST_SELECT_DR && t <= jtt_pkg::ST_UPDATE_DR);
      jtt_pkg::ST_CAPTURE_DR: return t != jtt_pkg::ST_SHIFT_DR;
      jtt_pkg::ST_SHIFT_DR:   return 1'b1;
      jtt_pkg::ST_EXIT1_DR:   return !(t == jtt_pkg::ST_PAUSE_DR || t == jtt_pkg::ST_EXIT2_DR);
      jtt_pkg::ST_PAUSE_DR:   return 1'b1;
      jtt_pkg::ST_EXIT2_DR:   return t != jtt_pkg::ST_SHIFT_DR;
      jtt_pkg::ST_UPDATE_DR:  return t != jtt_pkg::ST_IDLE;
      jtt_pkg::ST_SELECT_IR:  return !(t >= jtt_pkg::ST_SELECT_IR);
      jtt_pkg::ST_CAPTURE_IR: return t != jtt_pkg::ST_SHIFT_IR;
      jtt_pkg::ST_SHIFT_IR:   return 1'b1;
      jtt_pkg::ST_EXIT1_IR:   return !(t == jtt_pkg::ST_PAUSE_IR || t == jtt_pkg::ST_EXIT2_IR);
      jtt_pkg::ST_PAUSE_IR:   return 1'b1;
      jtt_pkg::ST_EXIT2_IR:   return t != jtt_pkg::ST_SHIFT_IR;
      default:                return t != jtt_pkg::ST_IDLE;
    endcase
  endfunction

  function automatic tms_path_t tms_path_for(tap_cmd_t c);
    tms_path_t p;
    logic [jtt_pkg::STATE_W-1:0] s;
    logic b;
    p.bits  = '0;
    p.count = '0;
    s = model_state;
    if (c.command == jtt_pkg::CMD_STEP) begin
      s = tap_next(s, c.tms);
      p.bits[0] = c.tms;
      p.count = jtt_pkg::TMS_COUNT_W'(1);
    end else begin
      for (int i = 0; i < PATH_STEPS && s != c.target; i++) begin
        b = walk_choice(s, c.target);
        p.bits[i] = b;
        p.count = p.count + jtt_pkg::TMS_COUNT_W'(1);
        s = tap_next(s, b);
      end
      s = c.target;
    end
    p.state = s;
    model_state = s;
    return p;
  endfunction

  function automatic logic send_gap();
    case (idle_mode)
      PH_SEND_IDLE: return $urandom_range(0, 99) < 83;
      PH_BOTH:      return $urandom_range(0, 99) < 17;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic logic recv_stall();
    case (idle_mode)
      PH_RECV_STALL: return $urandom_range(0, 99) < 83;
      PH_BOTH:       return $urandom_range(0, 99) < 17;
      default:       return 1'b0;
    endcase
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
    errors++;
  endtask

  task automatic push_cmd(logic cmd, logic [jtt_pkg::STATE_W-1:0] t, logic tms);
    tap_cmd_t c;
    c.command = cmd;
    c.target  = t;
    c.tms     = tms;
    cmd_queue.push_back(c);
  endtask

  task automatic wait_idle();
    while (cmd_queue.size() != 0 || path_queue.size() != 0 || cmd_valid)
      @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    logic took;
    took = cmd_valid && !cmd_stall;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (took) begin
        path_queue.push_back(tms_path_for(cmd_queue[0]));
        if (cmd_queue[0].command == jtt_pkg::CMD_STEP) steps_sent++;
        else gotos_sent++;
        cmd_queue.pop_front();
      end
      if (!cmd_valid || took) begin
        if (cmd_queue.size() != 0 && !send_gap()) begin
          cmd_valid    <= 1'b1;
          command      <= cmd_queue[0].command;
          target_state <= cmd_queue[0].target;
          tms_bit      <= cmd_queue[0].tms;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tms_path_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (path_queue.size() == 0) begin
          report("unexpected result, new_state", new_state, -1);
        end else begin
          want = path_queue.pop_front();
          if (tms_bits !== want.bits) report("tms_bits", tms_bits, want.bits);
          if (tms_count !== want.count) report("tms_count", tms_count, want.count);
          if (new_state !== want.state) report("new_state", new_state, want.state);
        end
      end
      rsp_stall <= recv_stall();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", path_queue.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // walk to every state in turn, starting at reset, the first one being the current state
    for (int s = 0; s < 16; s++)
      push_cmd(jtt_pkg::CMD_GOTO, s[jtt_pkg::STATE_W-1:0], s[0]);
    push_cmd(jtt_pkg::CMD_GOTO, jtt_pkg::ST_SHIFT_DR, 1'b1);
    push_cmd(jtt_pkg::CMD_GOTO, jtt_pkg::ST_SHIFT_IR, 1'b0);
    push_cmd(jtt_pkg::CMD_GOTO, jtt_pkg::ST_RESET, 1'b1);
    push_cmd(jtt_pkg::CMD_GOTO, jtt_pkg::ST_PAUSE_DR, 1'b0);
    // seven-bit path from pause dr
    push_cmd(jtt_pkg::CMD_GOTO, jtt_pkg::ST_PAUSE_IR, 1'b1);
    // raw steps, target ignored
    push_cmd(jtt_pkg::CMD_STEP, jtt_pkg::ST_UPDATE_IR, 1'b1);
    push_cmd(jtt_pkg::CMD_STEP, jtt_pkg::ST_RESET, 1'b0);
    push_cmd(jtt_pkg::CMD_STEP, 4'($urandom_range(0, 15)), 1'b1);
    push_cmd(jtt_pkg::CMD_STEP, 4'($urandom_range(0, 15)), 1'b0);
    wait_idle();

    for (int ph = PH_FREE; ph <= PH_BOTH; ph++) begin
      idle_mode = idle_mode_t'(ph);
      for (int i = 0; i < ITEMS_PHASE; i++)
        push_cmd(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                 1'($urandom_range(0, 1)));
      wait_idle();
    end

    idle_mode = PH_FREE;
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("covered %0d goto and %0d step transfers, %0d results checked",
             gotos_sent, steps_sent, results_seen);
    $display("idle patterns: free running, sender idle, receiver stall, both");
    if (errors == 0 && path_queue.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, path_queue.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
